>>> rtl/core/egcd_pkg.sv
`default_nettype none

package egcd_pkg;

  // Operand and remainder width, coefficient width.
  localparam int unsigned ValW  = 63;
  localparam int unsigned CoefW = 64;
  // Shift amount: quotient bit positions 0 .. ValW-1.
  localparam int unsigned ShW   = 6;

  typedef logic [ValW-1:0]  val_t;
  typedef logic [CoefW-1:0] coef_t;
  typedef logic [ShW-1:0]   sh_t;

  // Compare results of the shared divide unit.
  typedef struct packed {
    logic align_ok;  // r1 << (k+1) still fits under r0
    logic sub_ok;    // r1 << k fits under r0: quotient bit k is set
  } egcd_flags_t;

endpackage

`default_nettype wire

>>> rtl/core/egcd_div_unit.sv
`default_nettype none

// Shared shift-compare-subtract unit of one Euclid quotient step.
// Comparisons shift r0 right so nothing overflows; the subtractions apply
// quotient bit k to the remainder and both coefficient pairs at once.
module egcd_div_unit
  import egcd_pkg::*;
(
  input  val_t        r0_i,
  input  val_t        r1_i,
  input  coef_t       s0_i,
  input  coef_t       s1_i,
  input  coef_t       t0_i,
  input  coef_t       t1_i,
  input  sh_t         k_i,
  output egcd_flags_t flags_o,
  output val_t        r_diff_o,
  output coef_t       s_diff_o,
  output coef_t       t_diff_o
);

  logic [ShW:0] k_inc;

  assign k_inc = {1'b0, k_i} + {{ShW{1'b0}}, 1'b1};

  // r1 * 2^(k+1) <= r0  <=>  r1 <= floor(r0 / 2^(k+1))
  assign flags_o.align_ok = (r0_i >> k_inc) >= r1_i;
  assign flags_o.sub_ok   = (r0_i >> k_i) >= r1_i;

  // Only used when sub_ok holds, so the remainder difference stays in range.
  assign r_diff_o = r0_i - (r1_i << k_i);
  assign s_diff_o = s0_i - (s1_i << k_i);
  assign t_diff_o = t0_i - (t1_i << k_i);

endmodule

`default_nettype wire

>>> rtl/core/extended_gcd_unit.sv
// Extended GCD unit: gcd(a, b) and Bezout coefficients x, y, a*x + b*y = gcd.
// Input channel: in_valid_i/in_ready_o with first_value_i, second_value_i
// (63-bit unsigned). Output channel: out_valid_o/out_ready_i with divisor_o
// (63-bit unsigned), coeff_first_o and coeff_second_o (64-bit two's compl.).
// One transaction in gives one transaction out.
// Sequencing: each Euclid step uses one shared shift-compare-subtract
// unit, handling one quotient bit per cycle: first counting up the
// alignment, then producing the quotient bits from the top. The operands
// are loaded first, and the result is copied into the output register at
// the end. A zero second operand skips the Euclid steps entirely.
// Throughput: one transaction at a time; in_ready_o is high only while the
// unit is idle. A finished result sits in the output register, so a new
// transaction may start while the receiver stalls; the next result then
// waits until the output register is taken.
// Reset clears the sequencer and the output valid; nothing else persists.
`default_nettype none

module extended_gcd_unit
  import egcd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire val_t  first_value_i,
  input  wire val_t  second_value_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output val_t       divisor_o,
  output coef_t      coeff_first_o,
  output coef_t      coeff_second_o
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StAlign = 2'd1;
  localparam logic [1:0] StSub   = 2'd2;
  localparam logic [1:0] StFin   = 2'd3;

  logic [1:0]  state_q, state_d;
  sh_t         k_q, k_d;
  logic        out_valid_q, out_valid_d;
  val_t        r0_q, r0_d, r1_q, r1_d;
  coef_t       s0_q, s0_d, s1_q, s1_d, t0_q, t0_d, t1_q, t1_d;
  val_t        div_q;
  coef_t       cf_q, cs_q;
  logic        out_load;

  egcd_flags_t flags;
  val_t        r_diff, r_new;
  coef_t       s_diff, t_diff, s_new, t_new;

  egcd_div_unit u_div (
    .r0_i     (r0_q),
    .r1_i     (r1_q),
    .s0_i     (s0_q),
    .s1_i     (s1_q),
    .t0_i     (t0_q),
    .t1_i     (t1_q),
    .k_i      (k_q),
    .flags_o  (flags),
    .r_diff_o (r_diff),
    .s_diff_o (s_diff),
    .t_diff_o (t_diff)
  );

  // Values after quotient bit k has been applied
  assign r_new = flags.sub_ok ? r_diff : r0_q;
  assign s_new = flags.sub_ok ? s_diff : s0_q;
  assign t_new = flags.sub_ok ? t_diff : t0_q;

  assign in_ready_o = (state_q == StIdle);
  assign out_load   = (state_q == StFin) && (!out_valid_q || out_ready_i);

  // Sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    r0_d    = r0_q;
    r1_d    = r1_q;
    s0_d    = s0_q;
    s1_d    = s1_q;
    t0_d    = t0_q;
    t1_d    = t1_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          r0_d    = first_value_i;
          r1_d    = second_value_i;
          s0_d    = coef_t'(1);
          s1_d    = '0;
          t0_d    = '0;
          t1_d    = coef_t'(1);
          k_d     = '0;
          state_d = (second_value_i == '0) ? StFin : StAlign;
        end
      end
      StAlign: begin
        if (flags.align_ok) begin
          k_d = k_q + sh_t'(1);
        end else begin
          state_d = StSub;
        end
      end
      StSub: begin
        if (k_q == '0) begin
          // Quotient complete: rotate the pairs
          r0_d    = r1_q;
          r1_d    = r_new;
          s0_d    = s1_q;
          s1_d    = s_new;
          t0_d    = t1_q;
          t1_d    = t_new;
          state_d = (r_new == '0) ? StFin : StAlign;
        end else begin
          r0_d = r_new;
          s0_d = s_new;
          t0_d = t_new;
          k_d  = k_q - sh_t'(1);
        end
      end
      StFin: begin
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Output valid
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working registers and output register
  always_ff @(posedge clk_i) begin
    r0_q <= r0_d;
    r1_q <= r1_d;
    s0_q <= s0_d;
    s1_q <= s1_d;
    t0_q <= t0_d;
    t1_q <= t1_d;
    if (out_load) begin
      div_q <= r0_q;
      cf_q  <= s0_q;
      cs_q  <= t0_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign divisor_o      = div_q;
  assign coeff_first_o  = cf_q;
  assign coeff_second_o = cs_q;

endmodule

`default_nettype wire

>>> rtl/core/extended_gcd_unit_chk.sv
`default_nettype none

module extended_gcd_unit_chk
  import egcd_pkg::*;
(
  input wire logic  clk_i,
  input wire logic  rst_ni,
  input wire logic  in_valid_i,
  input wire logic  in_ready_o,
  input wire logic  out_valid_o,
  input wire logic  out_ready_i,
  input wire val_t  divisor_o,
  input wire coef_t coeff_first_o,
  input wire coef_t coeff_second_o
);

  // A stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      $stable(divisor_o) && $stable(coeff_first_o) && $stable(coeff_second_o))
    else $error("result payload changed while stalled");

  // Accepting a transaction makes the unit busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("unit ready right after accepting a transaction");

  // A zero divisor only comes from two zero operands: (0, 1, 0)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (divisor_o == '0) |->
      (coeff_first_o == coef_t'(1)) && (coeff_second_o == '0))
    else $error("zero gcd with wrong coefficients");

endmodule

bind extended_gcd_unit extended_gcd_unit_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .divisor_o      (divisor_o),
  .coeff_first_o  (coeff_first_o),
  .coeff_second_o (coeff_second_o)
);

`default_nettype wire

>>> test/extended_gcd_unit_test.sv
`default_nettype none

module extended_gcd_unit_test
  import egcd_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumRandom = 1850;
  localparam int unsigned DrainEvery = 250;
  localparam int unsigned TailCycles = 400;

  // One operand pair waiting to be sent; hold_for_drain makes the sender
  // wait until every outstanding result has been returned.
  typedef struct {
    val_t first;
    val_t second;
    bit   hold_for_drain;
  } operand_pair_t;

  typedef struct {
    val_t  divisor;
    coef_t coeff_first;
    coef_t coeff_second;
  } bezout_t;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_ready;
  val_t  first_value = '0;
  val_t  second_value = '0;
  logic  out_valid;
  logic  out_ready = 1'b0;
  val_t  divisor;
  coef_t coeff_first;
  coef_t coeff_second;

  operand_pair_t operand_q[$];
  bezout_t       bezout_q[$];
  int unsigned   err_cnt = 0;

  extended_gcd_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .first_value_i  (first_value),
    .second_value_i (second_value),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .divisor_o      (divisor),
    .coeff_first_o  (coeff_first),
    .coeff_second_o (coeff_second)
  );

  // Iterative extended Euclid, truncating division, wrapping at 64 bits.
  function automatic bezout_t bezout_of(val_t a, val_t b);
    logic [63:0] r0, r1, s0, s1, t0, t1, quo, nr, ns, nt;
    bezout_t res;
    r0 = {1'b0, a};
    r1 = {1'b0, b};
    s0 = 64'd1;
    s1 = 64'd0;
    t0 = 64'd0;
    t1 = 64'd1;
    while (r1 != 64'd0) begin
      quo = r0 / r1;
      nr  = r0 - quo * r1;
      ns  = s0 - quo * s1;
      nt  = t0 - quo * t1;
      r0  = r1;
      r1  = nr;
      s0  = s1;
      s1  = ns;
      t0  = t1;
      t1  = nt;
    end
    res.divisor      = r0[ValW-1:0];
    res.coeff_first  = s0;
    res.coeff_second = t0;
    return res;
  endfunction

  // Random value of the given bit width (1 .. ValW).
  function automatic val_t rand_val(int unsigned width);
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    raw = raw >> (64 - width);
    return raw[ValW-1:0];
  endfunction

  function automatic void push_pair(val_t a, val_t b, bit hold);
    operand_pair_t p;
    p.first = a;
    p.second = b;
    p.hold_for_drain = hold;
    operand_q.push_back(p);
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      err_cnt++;
    end
  endfunction

  // Clock and reset
  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Stimulus: directed corners, then random pairs of several shapes
  initial begin
    val_t fib [0:92];
    val_t vmax, a, b, g;
    logic [63:0] wide;
    int unsigned k, wg;
    fib[0] = '0;
    fib[1] = 63'd1;
    for (int i = 2; i <= 92; i++) fib[i] = fib[i-1] + fib[i-2];
    vmax = '1;

    // zero operands
    push_pair('0, '0, 1'b0);
    push_pair(63'd5, '0, 1'b0);
    push_pair('0, 63'd7, 1'b0);
    push_pair(vmax, '0, 1'b0);
    push_pair('0, vmax, 1'b0);
    // extremes
    push_pair(vmax, vmax, 1'b0);
    push_pair(vmax, 63'd1, 1'b0);
    push_pair(63'd1, vmax, 1'b0);
    push_pair(vmax, vmax - 63'd1, 1'b0);
    push_pair(vmax - 63'd1, vmax, 1'b0);
    push_pair(63'd1, 63'd1, 1'b0);
    push_pair(63'h4000_0000_0000_0000, 63'h2000_0000_0000_0000, 1'b0);
    push_pair(vmax, 63'h4000_0000_0000_0000, 1'b0);
    push_pair(63'd1, 63'h4000_0000_0000_0000, 1'b0);
    push_pair(63'd12, 63'd18, 1'b0);
    push_pair(63'd240, 63'd46, 1'b0);
    // longest step chains: consecutive Fibonacci numbers
    push_pair(fib[92], fib[91], 1'b0);
    push_pair(fib[91], fib[92], 1'b0);
    push_pair(fib[91], fib[90], 1'b0);
    // coprime pairs: two large operands, and a large one with a small one
    push_pair(63'h5555_5555_5555_5555, 63'h2AAA_AAAA_AAAA_AAAA, 1'b0);
    push_pair(vmax, 63'd3, 1'b0);

    for (int n = 0; n < NumRandom; n++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          a = rand_val(ValW);
          b = rand_val(ValW);
        end
        3, 4: begin
          a = rand_val($urandom_range(1, ValW));
          b = rand_val($urandom_range(1, ValW));
        end
        5: begin
          // common factor
          wg = $urandom_range(1, 31);
          g  = rand_val(wg);
          wide = {1'b0, g} * {1'b0, rand_val($urandom_range(1, ValW - wg))};
          a = wide[ValW-1:0];
          wide = {1'b0, g} * {1'b0, rand_val($urandom_range(1, ValW - wg))};
          b = wide[ValW-1:0];
        end
        6: begin
          k = $urandom_range(1, 91);
          if ($urandom_range(0, 1) != 0) begin
            a = fib[k+1];
            b = fib[k];
          end else begin
            a = fib[k];
            b = fib[k+1];
          end
        end
        7: begin
          a = rand_val(4);
          b = rand_val(4);
        end
        8: begin
          a = rand_val($urandom_range(1, ValW));
          b = ($urandom_range(0, 1) != 0) ? a : '0;
        end
        default: begin
          a = rand_val($urandom_range(1, ValW));
          b = '0;
          if ($urandom_range(0, 1) != 0) begin
            b = a;
            a = '0;
          end
        end
      endcase
      push_pair(a, b, (n % DrainEvery) == 0);
    end
  end

  // Input driver: bursts of random length with random gaps
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;

  always @(posedge clk or negedge rst_n) begin : drive_operands
    bit fire;
    logic nxt_valid;
    operand_pair_t p;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      fire = in_valid && in_ready;
      nxt_valid = in_valid;
      if (fire) begin
        bezout_q.push_back(bezout_of(first_value, second_value));
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (operand_q.size() != 0 &&
                     !(operand_q[0].hold_for_drain && bezout_q.size() != 0)) begin
          p = operand_q.pop_front();
          first_value <= p.first;
          second_value <= p.second;
          nxt_valid = 1'b1;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            case ($urandom_range(0, 3))
              0: gap_left = 0;
              1: gap_left = $urandom_range(1, 8);
              2: gap_left = $urandom_range(1, 400);
              default: gap_left = 0;
            endcase
          end
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // Result monitor with its own stall pattern
  int unsigned stall_mode = 0;
  int unsigned mode_left = 0;
  int unsigned cyc = 0;

  always @(posedge clk or negedge rst_n) begin : watch_results
    bezout_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
      cyc = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (bezout_q.size() == 0) begin
          $display("%0t: result with nothing outstanding, expected none, actual %h %h %h",
                   $time, divisor, coeff_first, coeff_second);
          err_cnt++;
        end else begin
          want = bezout_q.pop_front();
          check_field("divisor", {1'b0, want.divisor}, {1'b0, divisor});
          check_field("coeff_first", want.coeff_first, coeff_first);
          check_field("coeff_second", want.coeff_second, coeff_second);
        end
      end
      cyc++;
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(64, 1024);
      end else begin
        mode_left--;
      end
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 1) != 0);
        2: out_ready <= (cyc % 8) == 0;
        default: out_ready <= ($urandom_range(0, 15) == 0);
      endcase
    end
  end

  // End of run
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (operand_q.size() == 0 && !in_valid && bezout_q.size() == 0) break;
    end
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0 && bezout_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #100ms;
    $display("%0t: timeout", $time);
    $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire

>>> extended_gcd_unit.f
rtl/core/egcd_pkg.sv
rtl/core/egcd_div_unit.sv
rtl/core/extended_gcd_unit.sv
rtl/core/extended_gcd_unit_chk.sv
test/extended_gcd_unit_test.sv
